@@ hw/rtl/mwo_pkg.sv @@
// Shared types, constants and the quarter-wave sine table of the tone channel.
package mwo_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 8;
  localparam int SINE_N         = 1 << SINE_ADDR_BITS;
  localparam int PHASE_SUM_W    = (PHASE_BITS > 31) ? PHASE_BITS : 31;

  localparam int SAMPLE_W = 16;
  localparam int TBL_W    = 15;
  localparam int MAG0_W   = 17;
  localparam int ACC_W    = 48;
  localparam int SHAMT_W  = 5;

  localparam int          AMP_MAX      = 32767;
  localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
  localparam int          DIV255_SHIFT = 39;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_WAVEFORM = 1'b0;

  typedef logic [PHASE_BITS-1:0]  phase_t;
  typedef logic [PHASE_SUM_W-1:0] phase_sum_t;
  typedef logic [ACC_W-1:0]       acc_t;

  typedef enum logic [2:0] {
    WAVE_PULSE = 3'd0,
    WAVE_NOISE = 3'd1,
    WAVE_SAW   = 3'd2,
    WAVE_SINE  = 3'd3,
    WAVE_TRI   = 3'd4
  } wave_e;

  typedef enum logic [1:0] {
    OP_MUL_F,
    OP_MUL_VOL,
    OP_MUL_K,
    OP_DIV
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_VOL,
    ST_MUL_K,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } state_e;

  // Which multiply steps a sample needs, the shift ahead of the first divide
  // by 255, and the sign applied at the end.
  typedef struct packed {
    logic               mul_f;
    logic               mul_vol;
    logic               mul_k;
    logic               div2;
    logic [SHAMT_W-1:0] shamt;
    logic               neg;
  } plan_t;

  typedef struct packed {
    plan_t             plan;
    logic [MAG0_W-1:0] mag;
  } start_t;

  typedef logic [SINE_N*TBL_W-1:0] sine_rom_t;

  function automatic logic [63:0] taylor_div(input int idx, input logic [63:0] n);
    logic [63:0] q;
    case (idx)
      0:       q = n / 64'd156;
      1:       q = n / 64'd110;
      2:       q = n / 64'd72;
      3:       q = n / 64'd42;
      4:       q = n / 64'd20;
      default: q = n / 64'd6;
    endcase
    return q;
  endfunction

  // Q30 Taylor series of sin at the middle of each table step, to x^13.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] v;
    one = 64'd1 << 30;
    rom = '0;
    for (int k = 0; k < SINE_N; k++) begin
      x  = (64'd1686629713 * (64'(2 * k) + 64'd1)) >> (SINE_ADDR_BITS + 1);
      x2 = (x * x) >> 30;
      t  = one;
      for (int i = 0; i < 6; i++) begin
        d = taylor_div(i, (x2 * t) >> 30);
        t = (d > one) ? 64'd0 : (one - d);
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (one >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k*TBL_W +: TBL_W] = v[TBL_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ hw/rtl/mwo_mul_unit.sv @@
// Shared 32x32 multiplier: scaling steps and divide by 255 via a reciprocal.
module mwo_mul_unit (
  input  mwo_pkg::mul_op_e            op_i,
  input  mwo_pkg::acc_t               acc_i,
  input  logic [15:0]                 f_i,
  input  logic [7:0]                  vol_i,
  input  logic [mwo_pkg::SHAMT_W-1:0] shamt_i,
  output mwo_pkg::acc_t               acc_o
);

  logic [31:0]   opa;
  logic [31:0]   opb;
  logic [63:0]   prod;
  mwo_pkg::acc_t shifted;

  assign shifted = acc_i >> shamt_i;

  always_comb begin
    opa = acc_i[31:0];
    opb = '0;
    case (op_i)
      mwo_pkg::OP_MUL_F:   opb = {16'd0, f_i};
      mwo_pkg::OP_MUL_VOL: opb = {24'd0, vol_i};
      mwo_pkg::OP_MUL_K:   opb = 32'(mwo_pkg::AMP_MAX);
      mwo_pkg::OP_DIV: begin
        // Exact floor division by 255 for any 32-bit dividend.
        opa = shifted[31:0];
        opb = mwo_pkg::DIV255_MAGIC;
      end
      default: opb = '0;
    endcase
  end

  assign prod  = 64'(opa) * 64'(opb);
  assign acc_o = (op_i == mwo_pkg::OP_DIV) ? mwo_pkg::ACC_W'(prod >> mwo_pkg::DIV255_SHIFT)
                                           : prod[mwo_pkg::ACC_W-1:0];

endmodule

@@ hw/rtl/mwo_phase_gen.sv @@
// Phase accumulator, noise LFSR and per-waveform start value of each sample.
module mwo_phase_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [2:0]           waveform_i,
  input  logic                 restart_i,
  input  logic [30:0]          phase_step_i,
  input  logic [7:0]           volume_i,
  input  logic [7:0]           duty_i,
  output mwo_pkg::start_t      start_o,
  output logic [15:0]          f_o,
  output logic [7:0]           vol_o
);

  mwo_pkg::phase_t phase_q, phase_d;
  mwo_pkg::phase_t phase_eff;
  logic [15:0]     lfsr_q, lfsr_d, lfsr_next;
  logic [15:0]     f_q, f;
  logic [7:0]      vol_q;
  logic [7:0]      noise_byte;
  logic [23:0]     f255;
  logic [1:0]      quad;
  logic [mwo_pkg::SINE_ADDR_BITS-1:0] sine_addr, sine_idx;
  logic [mwo_pkg::TBL_W-1:0]          sine_val;

  assign phase_eff = restart_i ? '0 : phase_q;
  assign f         = phase_eff[mwo_pkg::PHASE_BITS-1 -: 16];
  assign phase_d   = mwo_pkg::PHASE_BITS'(mwo_pkg::phase_sum_t'(phase_eff)
                                          + mwo_pkg::phase_sum_t'(phase_step_i));

  assign lfsr_next  = lfsr_q[0] ? ((lfsr_q >> 1) ^ mwo_pkg::LFSR_TAPS) : (lfsr_q >> 1);
  assign noise_byte = (lfsr_next[7:0] == 8'hFF) ? 8'd0 : lfsr_next[7:0];

  assign f255      = {f, 8'h00} - 24'(f);
  assign quad      = f[15:14];
  assign sine_addr = f[13 -: mwo_pkg::SINE_ADDR_BITS];
  assign sine_idx  = quad[0] ? ~sine_addr : sine_addr;
  assign sine_val  = mwo_pkg::SINE_ROM[int'(sine_idx) * mwo_pkg::TBL_W +: mwo_pkg::TBL_W];

  always_comb begin
    start_o = '0;
    lfsr_d  = lfsr_q;
    case (waveform_i)
      mwo_pkg::WAVE_PULSE: begin
        start_o.mag        = mwo_pkg::MAG0_W'(volume_i);
        start_o.plan.mul_k = 1'b1;
        start_o.plan.neg   = !(f255 < {duty_i, 16'h0000});
      end
      mwo_pkg::WAVE_NOISE: begin
        lfsr_d               = lfsr_next;
        start_o.mag          = mwo_pkg::MAG0_W'(noise_byte);
        start_o.plan.mul_f   = 1'b1;
        start_o.plan.mul_vol = 1'b1;
        start_o.plan.mul_k   = 1'b1;
        start_o.plan.div2    = 1'b1;
        start_o.plan.shamt   = mwo_pkg::SHAMT_W'(16);
      end
      mwo_pkg::WAVE_SAW: begin
        // The phase read as a signed 16-bit value.
        start_o.mag          = f[15] ? (17'h10000 - 17'(f)) : 17'(f);
        start_o.plan.neg     = f[15];
        start_o.plan.mul_vol = 1'b1;
        start_o.plan.mul_k   = 1'b1;
        start_o.plan.shamt   = mwo_pkg::SHAMT_W'(15);
      end
      mwo_pkg::WAVE_SINE: begin
        start_o.mag          = mwo_pkg::MAG0_W'(sine_val);
        start_o.plan.neg     = quad[1];
        start_o.plan.mul_vol = 1'b1;
      end
      mwo_pkg::WAVE_TRI: begin
        if (quad == 2'd0) begin
          start_o.mag      = 17'(f);
          start_o.plan.neg = 1'b1;
        end else if (quad == 2'd1) begin
          start_o.mag      = 17'h08000 - 17'(f);
          start_o.plan.neg = 1'b1;
        end else if (quad == 2'd2) begin
          start_o.mag = 17'(f) - 17'h08000;
        end else begin
          start_o.mag = 17'h10000 - 17'(f);
        end
        start_o.plan.mul_vol = 1'b1;
        start_o.plan.mul_k   = 1'b1;
        start_o.plan.shamt   = mwo_pkg::SHAMT_W'(14);
      end
      default: start_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      lfsr_q  <= mwo_pkg::LFSR_SEED;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lfsr_q  <= lfsr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      f_q   <= f;
      vol_q <= volume_i;
    end
  end

  assign f_o   = f_q;
  assign vol_o = vol_q;

endmodule

@@ hw/rtl/multi_waveform_oscillator.sv @@
// Top level of the tone channel: register port, sequencer and output register.
//
// One request on the input channel is one sample tick carrying restart,
// phase_step, volume and duty. It is accepted when in_valid_i is high and
// in_stall_o is low, and it yields exactly one sample_out_o request on the
// output channel, taken when out_valid_o is high and out_stall_i is low.
// The waveform register (byte address 0) selects pulse, noise, sawtooth,
// sine or triangle; other codes give silence while the phase still advances.
// After acceptance a small sequencer runs the sample through one shared
// 32x32 multiplier, one step per cycle: scale by phase, volume or 32767 as
// the waveform needs, then divide by 255 once or twice by reciprocal multiply.
// No new request is accepted until the sequencer has finished the sample;
// how long that takes is set by the number of multiplier steps.
// After the last step the sample waits in the done state for the output register.
// The output register parts the two sides: the next request is accepted
// while a sample waits; only when a finished sample finds the output
// register still full and stalled does the sequencer hold, with in_stall_o
// high. Reset clears the phase, seeds the LFSR with 0xACE1, sets the
// waveform to pulse and empties the output register.
module multi_waveform_oscillator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mwo_pkg::ADDR_W-1:0]  paddr,
  input  logic [mwo_pkg::DATA_W-1:0]  pwdata,
  output logic [mwo_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  input  logic [30:0]                 phase_step_i,
  input  logic [7:0]                  volume_i,
  input  logic [7:0]                  duty_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          sample_out_o
);

  logic [2:0]             waveform_q;
  logic                   reg_sel;
  logic                   accept;
  mwo_pkg::state_e        state_q, state_d;
  mwo_pkg::plan_t         plan_q;
  mwo_pkg::start_t        start;
  mwo_pkg::acc_t          acc_q, acc_d, mul_res;
  mwo_pkg::mul_op_e       op;
  logic [mwo_pkg::SHAMT_W-1:0] shamt;
  logic [15:0]            f;
  logic [7:0]             vol;
  logic                   out_valid_q, out_valid_d;
  logic signed [15:0]     sample_q, sample_d;
  logic                   load_out;
  logic [14:0]            mag;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = paddr[mwo_pkg::ADDR_W-1];
  assign prdata  = (reg_sel == mwo_pkg::REG_WAVEFORM) ? mwo_pkg::DATA_W'(waveform_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= mwo_pkg::WAVE_PULSE;
    end else if (psel && penable && pwrite && (reg_sel == mwo_pkg::REG_WAVEFORM)) begin
      waveform_q <= pwdata[2:0];
    end
  end

  assign in_stall_o = (state_q != mwo_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  mwo_phase_gen u_phase_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .waveform_i   (waveform_q),
    .restart_i    (restart_i),
    .phase_step_i (phase_step_i),
    .volume_i     (volume_i),
    .duty_i       (duty_i),
    .start_o      (start),
    .f_o          (f),
    .vol_o        (vol)
  );

  always_comb begin
    case (state_q)
      mwo_pkg::ST_MUL_F:   op = mwo_pkg::OP_MUL_F;
      mwo_pkg::ST_MUL_VOL: op = mwo_pkg::OP_MUL_VOL;
      mwo_pkg::ST_MUL_K:   op = mwo_pkg::OP_MUL_K;
      default:             op = mwo_pkg::OP_DIV;
    endcase
  end

  // Only the first divide carries the waveform's shift.
  assign shamt = (state_q == mwo_pkg::ST_DIV1) ? plan_q.shamt : '0;

  mwo_mul_unit u_mul_unit (
    .op_i    (op),
    .acc_i   (acc_q),
    .f_i     (f),
    .vol_i   (vol),
    .shamt_i (shamt),
    .acc_o   (mul_res)
  );

  assign mag      = (acc_q > mwo_pkg::acc_t'(mwo_pkg::AMP_MAX)) ? 15'(mwo_pkg::AMP_MAX)
                                                                : acc_q[14:0];
  assign load_out = (state_q == mwo_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      mwo_pkg::ST_IDLE: begin
        if (accept) begin
          acc_d = mwo_pkg::acc_t'(start.mag);
          if (start.plan.mul_f) begin
            state_d = mwo_pkg::ST_MUL_F;
          end else if (start.plan.mul_vol) begin
            state_d = mwo_pkg::ST_MUL_VOL;
          end else if (start.plan.mul_k) begin
            state_d = mwo_pkg::ST_MUL_K;
          end else begin
            state_d = mwo_pkg::ST_DIV1;
          end
        end
      end
      mwo_pkg::ST_MUL_F: begin
        acc_d = mul_res;
        if (plan_q.mul_vol) begin
          state_d = mwo_pkg::ST_MUL_VOL;
        end else if (plan_q.mul_k) begin
          state_d = mwo_pkg::ST_MUL_K;
        end else begin
          state_d = mwo_pkg::ST_DIV1;
        end
      end
      mwo_pkg::ST_MUL_VOL: begin
        acc_d   = mul_res;
        state_d = plan_q.mul_k ? mwo_pkg::ST_MUL_K : mwo_pkg::ST_DIV1;
      end
      mwo_pkg::ST_MUL_K: begin
        acc_d   = mul_res;
        state_d = mwo_pkg::ST_DIV1;
      end
      mwo_pkg::ST_DIV1: begin
        acc_d   = mul_res;
        state_d = plan_q.div2 ? mwo_pkg::ST_DIV2 : mwo_pkg::ST_DONE;
      end
      mwo_pkg::ST_DIV2: begin
        acc_d   = mul_res;
        state_d = mwo_pkg::ST_DONE;
      end
      mwo_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = mwo_pkg::ST_IDLE;
        end
      end
      default: state_d = mwo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      sample_d    = plan_q.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    sample_q <= sample_d;
    if (accept) begin
      plan_q <= start.plan;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;

endmodule

@@ sim/tb_multi_waveform_oscillator.sv @@
// Self-checking testbench of the tone channel: random note streams with stalls on both sides.
module tb_multi_waveform_oscillator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_IDLE      = 11;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 32;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_TICKS  = 1800;
  localparam int WAVE_CODES    = 8;
  localparam int SINE_LEN      = 256;

  localparam logic [mwo_pkg::ADDR_W-1:0] WAVE_ADDR =
    mwo_pkg::ADDR_W'(4 * mwo_pkg::REG_WAVEFORM);
  localparam logic [15:0] NOISE_SEED = 16'hACE1;
  localparam logic [15:0] NOISE_TAPS = 16'hB400;
  localparam logic [30:0] STEP_MAX   = 31'h7FFF_FFFF;

  // Tracks the channel state, predicts each sample and checks what comes out.
  class tone_tracker;
    logic [2:0]         wave_sel;
    logic [31:0]        phase;
    logic [15:0]        lfsr;
    longint             quarter_sine[SINE_LEN];
    logic signed [15:0] pending_samples[$];
    int                 failures;

    function new();
      wave_sel = mwo_pkg::WAVE_PULSE;
      phase    = '0;
      lfsr     = NOISE_SEED;
      failures = 0;
      for (int k = 0; k < SINE_LEN; k++) begin
        quarter_sine[k] = sine_point(k);
      end
    endfunction

    // Sine at the middle of table step k, Q30 Taylor series up to x^13.
    function longint sine_point(int k);
      bit [63:0] series_div[6];
      bit [63:0] q30;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] t;
      bit [63:0] d;
      bit [63:0] s;
      bit [63:0] v;
      series_div = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      q30 = 64'd1 << 30;
      x   = (64'd1686629713 * 64'(2 * k + 1)) / 64'(2 * SINE_LEN);
      x2  = (x * x) >> 30;
      t   = q30;
      for (int i = 0; i < 6; i++) begin
        d = ((x2 * t) >> 30) / series_div[i];
        t = (d > q30) ? 64'd0 : (q30 - d);
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return longint'(v);
    endfunction

    function void set_waveform(logic [2:0] code);
      wave_sel = code;
    endfunction

    function logic signed [15:0] predict_sample(logic restart, logic [30:0] step,
                                                logic [7:0] vol, logic [7:0] duty);
      longint f;
      longint lvl;
      longint res;
      longint x;
      longint t;
      int     addr;
      if (restart) begin
        phase = '0;
      end
      f   = longint'(phase[31:16]);
      lvl = longint'(vol);
      case (wave_sel)
        mwo_pkg::WAVE_PULSE: begin
          res = (32767 * lvl) / 255;
          if (f * 255 >= longint'(duty) * 65536) begin
            res = -res;
          end
        end
        mwo_pkg::WAVE_NOISE: begin
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ NOISE_TAPS) : (lfsr >> 1);
          x    = longint'(lfsr[7:0]) % 255;
          res  = (x * f * lvl * 32767) / (longint'(255) * 65536 * 255);
        end
        mwo_pkg::WAVE_SAW: begin
          x   = phase[31] ? f - 65536 : f;
          res = (x * lvl * 32767) / (longint'(32768) * 255);
        end
        mwo_pkg::WAVE_SINE: begin
          addr = int'(phase[29:22]);
          t    = phase[30] ? quarter_sine[SINE_LEN - 1 - addr] : quarter_sine[addr];
          if (phase[31]) begin
            t = -t;
          end
          res = (t * lvl) / 255;
        end
        mwo_pkg::WAVE_TRI: begin
          if (f < 16384) begin
            x = -f;
          end else if (f < 49152) begin
            x = f - 32768;
          end else begin
            x = 65536 - f;
          end
          res = (x * lvl * 32767) / (longint'(16384) * 255);
        end
        default: res = 0;
      endcase
      if (res > 32767) begin
        res = 32767;
      end
      if (res < -32767) begin
        res = -32767;
      end
      phase = phase + {1'b0, step};
      return res[15:0];
    endfunction

    function void note_tick(logic restart, logic [30:0] step, logic [7:0] vol,
                            logic [7:0] duty);
      pending_samples.insert(pending_samples.size(),
                             predict_sample(restart, step, vol, duty));
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, actual %0d", $time, got);
        failures++;
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) begin
          $display("%0t: sample mismatch: expected %0d, actual %0d", $time, want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mwo_pkg::ADDR_W-1:0]    paddr;
  logic [mwo_pkg::DATA_W-1:0]    pwdata;
  logic [mwo_pkg::DATA_W-1:0]    prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          restart_i;
  logic [30:0]                   phase_step_i;
  logic [7:0]                    volume_i;
  logic [7:0]                    duty_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [15:0]            sample_out_o;

  tone_tracker tracker;
  bit          send_calm;
  bit          recv_calm;
  bit          hold_off_req;
  int          quiet_cycles = 0;

  multi_waveform_oscillator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .phase_step_i(phase_step_i),
    .volume_i    (volume_i),
    .duty_i      (duty_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_out_o(sample_out_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Random idle length, with runs of back-to-back traffic now and then.
  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [7:0] draw_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [30:0] draw_step();
    case ($urandom_range(0, 7))
      0:       return 31'd0;
      1:       return STEP_MAX;
      2, 3:    return 31'($urandom());
      default: return 31'($urandom_range(1, 32'h0100_0000));
    endcase
  endfunction

  task automatic send_tick(input logic restart, input logic [30:0] step,
                           input logic [7:0] vol, input logic [7:0] duty);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      send_calm = !send_calm;
    end
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    restart_i    <= restart;
    phase_step_i <= step;
    volume_i     <= vol;
    duty_i       <= duty;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    tracker.note_tick(restart, step, vol, duty);
  endtask

  // Waits until every sample is back; the block is idle from then on.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_waveform(input logic [2:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WAVE_ADDR;
    pwdata  <= {29'($urandom()), code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_waveform(code);
    // Read the register back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[2:0] !== code) begin
      $display("%0t: waveform readback mismatch: expected %0d, actual %0d",
               $time, code, prdata[2:0]);
      tracker.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Notes: usually a restart, then a run of ticks at one pitch with occasional level changes.
  task automatic play_notes(input int count);
    int          left;
    int          note_len;
    logic        restart;
    logic [30:0] step;
    logic [7:0]  vol;
    logic [7:0]  duty;
    left = count;
    while (left > 0) begin
      note_len = $urandom_range(1, 40);
      step     = draw_step();
      vol      = draw_level();
      duty     = draw_level();
      for (int i = 0; i < note_len && left > 0; i++) begin
        if (i == 0) begin
          restart = ($urandom_range(0, 7) != 0);
        end else begin
          restart = ($urandom_range(0, 31) == 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          vol = draw_level();
        end
        if ($urandom_range(0, 15) == 0) begin
          duty = draw_level();
        end
        send_tick(restart, step, vol, duty);
        left--;
      end
    end
  endtask

  // Output side: random stalls per request, one long hold-off on demand.
  initial begin
    int gap;
    bit held;
    held        = 1'b0;
    recv_calm   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        recv_calm = !recv_calm;
      end
      gap = idle_cycles(recv_calm);
      if (hold_off_req && !held) begin
        gap  = LONG_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      tracker.check_sample(sample_out_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int total;
    int phase_idx;
    int phase_len;
    tracker      = new();
    send_calm    = 1'b0;
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    restart_i    = 1'b0;
    phase_step_i = '0;
    volume_i     = '0;
    duty_i       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every code, including the undefined ones; the phase walks 0, 0x7FFF, 0xFFFF and wraps.
    for (int code = 0; code < WAVE_CODES; code++) begin
      write_waveform(3'(code));
      send_tick(1'b1, STEP_MAX, 8'hFF, 8'hFF);
      send_tick(1'b0, STEP_MAX, 8'hFF, 8'h00);
      send_tick(1'b0, STEP_MAX, 8'h00, 8'h80);
      drain();
    end

    total     = 0;
    phase_idx = 0;
    while (total < RANDOM_TICKS) begin
      if (phase_idx < WAVE_CODES) begin
        write_waveform(3'(phase_idx));
      end else begin
        write_waveform(3'($urandom_range(0, WAVE_CODES - 1)));
      end
      // Keep the output side stalled for a while so the block backs up.
      if (phase_idx == 2) begin
        hold_off_req = 1'b1;
      end
      phase_len = $urandom_range(120, 220);
      play_notes(phase_len);
      drain();
      total += phase_len;
      phase_idx++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, tracker.pending_samples.size());
    end
    if (tracker.failures == 0 && tracker.pending_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
